/* hw/rtl/binary_heap_priority_queue_core_defines.svh */
// Assertion macros for the heap queue core.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BHPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhpq assertion failed");
`define BHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhpq assertion failed");
`else
`define BHPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/bhpq_pkg.sv */
package bhpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_TAG_BITS    = 16;

    localparam int OUT_KEY_W   = 32;
    localparam int OUT_TAG_W   = 16;
    localparam int COUNT_W     = 11;
    localparam int KEY_CMP_W   = 48;
    localparam int M_KEY_LSB   = 0;
    localparam int M_TAG_LSB   = M_KEY_LSB + OUT_KEY_W;
    localparam int M_COUNT_LSB = M_TAG_LSB + OUT_TAG_W;
    localparam int M_FIELDS_W  = M_COUNT_LSB + COUNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_ORDER_MAX = 1'b0;

    typedef enum logic [1:0] {
        STAT_ENQUEUED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_DEQUEUED = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_LOAD,
        S_SIFT_UP,
        S_SIFT_DOWN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start_push;
        logic drop_full;
        logic start_pop;
        logic drop_empty;
        logic pop_load;
        logic up_step;
        logic down_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic up_done;
        logic down_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic beats(logic order_max, logic [KEY_CMP_W-1:0] a,
                                   logic [KEY_CMP_W-1:0] b);
        return order_max ? (a > b) : (a < b);
    endfunction

endpackage

/* hw/rtl/bhpq_ram.sv */
module bhpq_ram #(
    parameter int WIDTH = bhpq_pkg::DEF_KEY_BITS + bhpq_pkg::DEF_TAG_BITS,
    parameter int DEPTH = bhpq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* hw/rtl/bhpq_ctrl.sv */
module bhpq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  bhpq_pkg::op_t      op,
    input  bhpq_pkg::dp_stat_t stat,
    output logic               s_tready,
    output bhpq_pkg::dp_cmd_t  cmd
);

    bhpq_pkg::state_t state_reg;
    bhpq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bhpq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bhpq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (op == bhpq_pkg::OP_ENQUEUE) begin
                        state_next = stat.full ? bhpq_pkg::S_FINISH : bhpq_pkg::S_SIFT_UP;
                    end else begin
                        state_next = stat.empty ? bhpq_pkg::S_FINISH : bhpq_pkg::S_POP_LOAD;
                    end
                end
            end
            bhpq_pkg::S_POP_LOAD: begin
                state_next = bhpq_pkg::S_SIFT_DOWN;
            end
            bhpq_pkg::S_SIFT_UP: begin
                if (stat.up_done) begin
                    state_next = bhpq_pkg::S_FINISH;
                end
            end
            bhpq_pkg::S_SIFT_DOWN: begin
                if (stat.down_done) begin
                    state_next = bhpq_pkg::S_FINISH;
                end
            end
            bhpq_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    state_next = bhpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bhpq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            bhpq_pkg::S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    if (op == bhpq_pkg::OP_ENQUEUE) begin
                        cmd.drop_full  = stat.full;
                        cmd.start_push = !stat.full;
                    end else begin
                        cmd.drop_empty = stat.empty;
                        cmd.start_pop  = !stat.empty;
                    end
                end
            end
            bhpq_pkg::S_POP_LOAD: begin
                cmd.pop_load = 1'b1;
            end
            bhpq_pkg::S_SIFT_UP: begin
                cmd.up_step = 1'b1;
            end
            bhpq_pkg::S_SIFT_DOWN: begin
                cmd.down_step = 1'b1;
            end
            bhpq_pkg::S_FINISH: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/bhpq_dp.sv */
module bhpq_dp #(
    parameter int QUEUE_DEPTH = bhpq_pkg::DEF_QUEUE_DEPTH,
    parameter int KEY_BITS    = bhpq_pkg::DEF_KEY_BITS,
    parameter int TAG_BITS    = bhpq_pkg::DEF_TAG_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               order_max,
    input  logic [KEY_BITS-1:0]                in_key,
    input  logic [TAG_BITS-1:0]                in_tag,
    input  bhpq_pkg::dp_cmd_t                  cmd,
    output bhpq_pkg::dp_stat_t                 stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bhpq_pkg::OUT_KEY_W-1:0]     m_key,
    output logic [bhpq_pkg::OUT_TAG_W-1:0]     m_tag,
    output bhpq_pkg::status_t                  m_status,
    output logic [bhpq_pkg::COUNT_W-1:0]       m_count
);

    localparam int ENTRY_W = KEY_BITS + TAG_BITS;
    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int SW      = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W   = bhpq_pkg::KEY_CMP_W;
    localparam int OKW     = bhpq_pkg::OUT_KEY_W;
    localparam int OTW     = bhpq_pkg::OUT_TAG_W;
    localparam int CW      = bhpq_pkg::COUNT_W;

    logic [ENTRY_W-1:0]  item_reg;
    logic [SW-1:0]       pos_reg;
    logic [SW-1:0]       cnt_reg;
    logic [KEY_BITS-1:0] res_key_reg;
    logic [TAG_BITS-1:0] res_tag_reg;
    bhpq_pkg::status_t   res_status_reg;

    logic                out_valid_reg;
    logic [OKW-1:0]      out_key_reg;
    logic [OTW-1:0]      out_tag_reg;
    bhpq_pkg::status_t   out_status_reg;
    logic [CW-1:0]       out_count_reg;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [SW+1:0]       rd_slot_a;
    logic [SW+1:0]       rd_slot_b;
    logic [ENTRY_W-1:0]  rd_data_a;
    logic [ENTRY_W-1:0]  rd_data_b;

    logic [KEY_BITS-1:0] rd_key_a;
    logic [KEY_BITS-1:0] rd_key_b;
    logic [KEY_BITS-1:0] item_key;
    logic [SW:0]         cnt_ext;
    logic [SW:0]         left_slot;
    logic [SW:0]         right_slot;
    logic                no_left;
    logic                no_right;
    logic                pick_right;
    logic [ENTRY_W-1:0]  pick_entry;
    logic [SW:0]         pick_slot;
    logic                down_move;
    logic [SW-1:0]       parent_slot;
    logic                up_move;
    logic [SW-1:0]       push_slot;

    bhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_heap_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (AW'(rd_slot_a - (SW+2)'(1))),
        .rd_data_a (rd_data_a),
        .rd_addr_b (AW'(rd_slot_b - (SW+2)'(1))),
        .rd_data_b (rd_data_b)
    );

    assign rd_key_a    = rd_data_a[KEY_BITS-1:0];
    assign rd_key_b    = rd_data_b[KEY_BITS-1:0];
    assign item_key    = item_reg[KEY_BITS-1:0];
    assign cnt_ext     = (SW+1)'(cnt_reg);
    assign left_slot   = {pos_reg, 1'b0};
    assign right_slot  = {pos_reg, 1'b1};
    assign no_left     = left_slot > cnt_ext;
    assign no_right    = right_slot > cnt_ext;
    assign pick_right  = !no_right
                         && !bhpq_pkg::beats(order_max, CMP_W'(rd_key_a), CMP_W'(rd_key_b));
    assign pick_entry  = pick_right ? rd_data_b : rd_data_a;
    assign pick_slot   = pick_right ? right_slot : left_slot;
    assign down_move   = !no_left
                         && bhpq_pkg::beats(order_max, CMP_W'(pick_entry[KEY_BITS-1:0]),
                                            CMP_W'(item_key));
    assign parent_slot = pos_reg >> 1;
    assign up_move     = (parent_slot != '0)
                         && bhpq_pkg::beats(order_max, CMP_W'(item_key), CMP_W'(rd_key_a));
    assign push_slot   = cnt_reg + SW'(1);

    always_comb begin
        rd_slot_a = '0;
        rd_slot_b = '0;
        if (cmd.start_push) begin
            rd_slot_a = (SW+2)'(push_slot >> 1);
        end else if (cmd.start_pop) begin
            rd_slot_a = (SW+2)'(1);
            rd_slot_b = (SW+2)'(cnt_reg);
        end else if (cmd.pop_load) begin
            rd_slot_a = (SW+2)'(2);
            rd_slot_b = (SW+2)'(3);
        end else if (cmd.up_step) begin
            rd_slot_a = (SW+2)'(pos_reg >> 2);
        end else if (cmd.down_step) begin
            rd_slot_a = {pick_slot, 1'b0};
            rd_slot_b = {pick_slot, 1'b1};
        end
    end

    always_comb begin
        wr_en   = cmd.up_step || cmd.down_step;
        wr_addr = AW'(pos_reg - SW'(1));
        wr_data = item_reg;
        if (cmd.up_step && up_move) begin
            wr_data = rd_data_a;
        end else if (cmd.down_step && down_move) begin
            wr_data = pick_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.start_push) begin
            cnt_reg <= push_slot;
        end else if (cmd.pop_load) begin
            cnt_reg <= cnt_reg - SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_push) begin
            item_reg       <= {in_tag, in_key};
            pos_reg        <= push_slot;
            res_key_reg    <= '0;
            res_tag_reg    <= '0;
            res_status_reg <= bhpq_pkg::STAT_ENQUEUED;
        end else if (cmd.drop_full) begin
            res_key_reg    <= '0;
            res_tag_reg    <= '0;
            res_status_reg <= bhpq_pkg::STAT_FULL;
        end else if (cmd.drop_empty) begin
            res_key_reg    <= '0;
            res_tag_reg    <= '0;
            res_status_reg <= bhpq_pkg::STAT_EMPTY;
        end else if (cmd.pop_load) begin
            item_reg       <= rd_data_b;
            pos_reg        <= SW'(1);
            res_key_reg    <= rd_key_a;
            res_tag_reg    <= rd_data_a[ENTRY_W-1:KEY_BITS];
            res_status_reg <= bhpq_pkg::STAT_DEQUEUED;
        end else if (cmd.up_step && up_move) begin
            pos_reg <= parent_slot;
        end else if (cmd.down_step && down_move) begin
            pos_reg <= SW'(pick_slot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_key_reg    <= OKW'(res_key_reg);
            out_tag_reg    <= OTW'(res_tag_reg);
            out_status_reg <= res_status_reg;
            out_count_reg  <= CW'(cnt_reg);
        end
    end

    assign stat.full      = cnt_reg == SW'(QUEUE_DEPTH);
    assign stat.empty     = cnt_reg == '0;
    assign stat.up_done   = !up_move;
    assign stat.down_done = !down_move;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_key    = out_key_reg;
    assign m_tag    = out_tag_reg;
    assign m_status = out_status_reg;
    assign m_count  = out_count_reg;

endmodule

/* hw/rtl/binary_heap_priority_queue_core.sv */
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tdata {tag, key}, tuser operation
// m_       out  m_tvalid/m_tready  tdata {count, out_tag, out_key}, tuser status
// apb      in   psel/penable       order_max at byte address 0
//
// Enqueue runs IDLE, SIFT_UP, FINISH, dequeue IDLE, POP_LOAD, SIFT_DOWN,
// FINISH; full and empty cases go from IDLE to FINISH. Sifting walks up to
// log2(QUEUE_DEPTH) heap levels, one level per cycle, set by the two-read,
// one-write heap RAM port pair. m_tvalid rises with s_tready in the same cycle.
// One item at a time; the result register lets the next item in while a
// result waits. A stalled output holds the finished item until taken.
// Reset empties the queue, selects smallest-key-first order, holds s_tready low.
`include "binary_heap_priority_queue_core_defines.svh"

module binary_heap_priority_queue_core #(
    parameter int QUEUE_DEPTH = bhpq_pkg::DEF_QUEUE_DEPTH,
    parameter int KEY_BITS    = bhpq_pkg::DEF_KEY_BITS,
    parameter int TAG_BITS    = bhpq_pkg::DEF_TAG_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // key, tag
    input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_key, out_tag, count
    output logic [bhpq_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [1:0]                          m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bhpq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bhpq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bhpq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int OKW = bhpq_pkg::OUT_KEY_W;
    localparam int OTW = bhpq_pkg::OUT_TAG_W;
    localparam int CW  = bhpq_pkg::COUNT_W;
    localparam int PAD = bhpq_pkg::M_TDATA_W - bhpq_pkg::M_FIELDS_W;

    logic                order_max_reg;
    bhpq_pkg::dp_cmd_t   cmd;
    bhpq_pkg::dp_stat_t  stat;
    logic [OKW-1:0]      m_key;
    logic [OTW-1:0]      m_tag;
    bhpq_pkg::status_t   m_status;
    logic [CW-1:0]       m_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_max_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == bhpq_pkg::REG_ORDER_MAX) begin
            order_max_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bhpq_pkg::REG_ORDER_MAX)
                    ? bhpq_pkg::APB_DATA_W'(order_max_reg) : '0;

    bhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (bhpq_pkg::op_t'(s_tuser)),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    bhpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .order_max (order_max_reg),
        .in_key    (s_tdata[KEY_BITS-1:0]),
        .in_tag    (s_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_key     (m_key),
        .m_tag     (m_tag),
        .m_status  (m_status),
        .m_count   (m_count)
    );

    assign m_tdata = {PAD'(0), m_count, m_tag, m_key};
    assign m_tuser = m_status;

    `BHPQ_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn,
        s_tvalid && s_tready, !s_tready)
    `BHPQ_ASSERT_IMPLY(a_payload_zero_unless_dequeued, aclk, aresetn,
        m_tvalid && m_tuser != bhpq_pkg::STAT_DEQUEUED, m_key == '0 && m_tag == '0)
    `BHPQ_ASSERT_IMPLY(a_full_reports_depth, aclk, aresetn,
        m_tvalid && m_tuser == bhpq_pkg::STAT_FULL, m_count == CW'(QUEUE_DEPTH))
    `BHPQ_ASSERT_IMPLY(a_empty_reports_zero, aclk, aresetn,
        m_tvalid && m_tuser == bhpq_pkg::STAT_EMPTY, m_count == '0)

endmodule

/* verif/heap_check_pkg.sv */
`timescale 1ns / 100ps

package heap_check_pkg;

    import bhpq_pkg::*;

    localparam int HEAP_SLOTS = bhpq_pkg::DEF_QUEUE_DEPTH;

    typedef struct {
        logic [OUT_KEY_W-1:0] key;
        logic [OUT_TAG_W-1:0] tag;
        status_t              status;
        logic [COUNT_W-1:0]   count;
    } heap_reply_t;

    class heap_scoreboard;
        logic [DEF_KEY_BITS-1:0] heap_key [1:HEAP_SLOTS];
        logic [DEF_TAG_BITS-1:0] heap_tag [1:HEAP_SLOTS];
        int unsigned             level;
        bit                      order_max;
        heap_reply_t             pending_replies [$];
        int                      errors;
        int                      n_pushed;
        int                      n_dropped;
        int                      n_popped;
        int                      n_empty;

        function new();
            level     = 0;
            order_max = 1'b0;
            errors    = 0;
            n_pushed  = 0;
            n_dropped = 0;
            n_popped  = 0;
            n_empty   = 0;
        endfunction

        function bit wins(logic [DEF_KEY_BITS-1:0] a, logic [DEF_KEY_BITS-1:0] b);
            return order_max ? (a > b) : (a < b);
        endfunction

        function void apply_operation(op_t op, logic [DEF_KEY_BITS-1:0] key,
                                      logic [DEF_TAG_BITS-1:0] tag);
            heap_reply_t             reply;
            int unsigned             pos;
            int unsigned             child;
            logic [DEF_KEY_BITS-1:0] last_key;
            logic [DEF_TAG_BITS-1:0] last_tag;
            reply.key = '0;
            reply.tag = '0;
            if (op == OP_ENQUEUE) begin
                if (level >= HEAP_SLOTS) begin
                    reply.status = STAT_FULL;
                end else begin
                    // sift up while strictly better than the parent
                    pos = level + 1;
                    while (pos > 1 && wins(key, heap_key[pos / 2])) begin
                        heap_key[pos] = heap_key[pos / 2];
                        heap_tag[pos] = heap_tag[pos / 2];
                        pos = pos / 2;
                    end
                    heap_key[pos] = key;
                    heap_tag[pos] = tag;
                    level++;
                    reply.status = STAT_ENQUEUED;
                end
            end else if (level == 0) begin
                reply.status = STAT_EMPTY;
            end else begin
                reply.key    = heap_key[1];
                reply.tag    = heap_tag[1];
                reply.status = STAT_DEQUEUED;
                last_key     = heap_key[level];
                last_tag     = heap_tag[level];
                level--;
                pos = 1;
                while (1) begin
                    child = pos * 2;
                    if (child > level)
                        break;
                    // left only if strictly better than right
                    if (child + 1 <= level && !wins(heap_key[child], heap_key[child + 1]))
                        child++;
                    if (!wins(heap_key[child], last_key))
                        break;
                    heap_key[pos] = heap_key[child];
                    heap_tag[pos] = heap_tag[child];
                    pos = child;
                end
                heap_key[pos] = last_key;
                heap_tag[pos] = last_tag;
            end
            reply.count = COUNT_W'(level);
            pending_replies.push_back(reply);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [M_TDATA_W-1:0] data, logic [1:0] user);
            heap_reply_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transfer, actual data %0h status %0h",
                         $time, data, user);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("out_key", 32'(want.key), 32'(data[M_KEY_LSB +: OUT_KEY_W]));
            compare_field("out_tag", 32'(want.tag), 32'(data[M_TAG_LSB +: OUT_TAG_W]));
            compare_field("count", 32'(want.count), 32'(data[M_COUNT_LSB +: COUNT_W]));
            compare_field("status", 32'(want.status), 32'(user));
            case (want.status)
                STAT_ENQUEUED: n_pushed++;
                STAT_FULL:     n_dropped++;
                STAT_DEQUEUED: n_popped++;
                default:       n_empty++;
            endcase
        endfunction
    endclass

endpackage

/* verif/binary_heap_priority_queue_core_tb.sv */
`timescale 1ns / 100ps

module binary_heap_priority_queue_core_tb;

    import bhpq_pkg::*;
    import heap_check_pkg::*;

    localparam int S_TDATA_W  = ((DEF_KEY_BITS + DEF_TAG_BITS + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int END_SETTLE = 40;
    localparam logic [APB_ADDR_W-1:0] ORDER_ADDR = APB_ADDR_W'(4 * int'(REG_ORDER_MAX));

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // key, tag
    logic                  s_tuser  = 1'b0; // operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // out_key, out_tag, count
    logic [1:0]            m_tuser;         // status
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    heap_scoreboard sb;
    bit             feed_steady = 1'b0;
    bit             sink_steady = 1'b0;
    int             stall_left  = 0;
    int             idle_cycles = 0;

    binary_heap_priority_queue_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(0, 15));
            7:          return 32'h0;
            8:          return 32'hFFFF_FFFF;
            default:    return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
        endcase
    endfunction

    // receive side: random stalls, check every transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_reply(m_tdata, m_tuser);
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                stall_left <= pick_gap(sink_steady);
            end
            if ($urandom_range(0, 199) == 0)
                sink_steady <= !sink_steady;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_op(op_t op, logic [31:0] key, logic [15:0] tag);
        int gap;
        gap = pick_gap(feed_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tag, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.apply_operation(op, key, tag);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic set_order(bit order);
        wait_drained();
        paddr   <= ORDER_ADDR;
        pwdata  <= APB_DATA_W'(order);
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[0] !== order) begin
            $display("%0t: order_max readback mismatch, expected %0h, actual %0h",
                     $time, order, prdata[0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.order_max = order;
    endtask

    task automatic run_mix(int n, int deq_pct);
        op_t op;
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0)
                feed_steady = ($urandom_range(0, 3) == 0);
            op = ($urandom_range(0, 99) < deq_pct) ? OP_DEQUEUE : OP_ENQUEUE;
            send_op(op, rand_key(), 16'($urandom));
        end
        feed_steady = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_order(1'b0);
        send_op(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(OP_ENQUEUE, 32'h0, 16'hFFFF);
        send_op(OP_ENQUEUE, 32'hFFFF_FFFF, 16'h0);
        send_op(OP_ENQUEUE, 32'd5, 16'd1);
        send_op(OP_ENQUEUE, 32'd5, 16'd2);
        send_op(OP_ENQUEUE, 32'd5, 16'd3);
        send_op(OP_ENQUEUE, 32'd7, 16'hAAAA);
        send_op(OP_ENQUEUE, 32'd3, 16'h5555);
        send_op(OP_ENQUEUE, 32'h0, 16'h1234);
        repeat (9) send_op(OP_DEQUEUE, $urandom, 16'($urandom));
        run_mix(200, 45);

        // largest first, fill to capacity and push against it
        set_order(1'b1);
        while (sb.level < HEAP_SLOTS)
            send_op(OP_ENQUEUE, rand_key(), 16'($urandom));
        run_mix(12, 30);
        run_mix(250, 65);

        // flip the order with a populated heap
        set_order(1'b0);
        run_mix(150, 55);

        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        $display("Covered %0d enqueues, %0d full drops, %0d dequeues, %0d empty dequeues,",
                 sb.n_pushed, sb.n_dropped, sb.n_popped, sb.n_empty);
        $display("with both key orders and an order change on a non-empty heap");
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/bhpq_pkg.sv
hw/rtl/bhpq_ram.sv
hw/rtl/bhpq_ctrl.sv
hw/rtl/bhpq_dp.sv
hw/rtl/binary_heap_priority_queue_core.sv
verif/heap_check_pkg.sv
verif/binary_heap_priority_queue_core_tb.sv
